[rtl/dcd_pkg.sv]
package dcd_pkg;

	// Field and datapath widths
	localparam int CH_W      = 4;
	localparam int SAMPLE_W  = 16;
	localparam int FRAC_BITS = 24;
	localparam int STATE_W   = 40;
	localparam int COEF_W    = 24;
	localparam int THR_W     = 15;
	localparam int DC_W      = 16;
	localparam int LEVEL_W   = 12;
	localparam int CFG_IDX_W = 2;

	localparam int NUM_CHANNELS_DEF = 16;

	// Register reset values
	localparam logic [COEF_W-1:0] COEF_RESET = 24'd2390;
	localparam logic [THR_W-1:0]  THR_RESET  = 15'd102;

	// Output limits: +-10 V for the DC value, 0.25 V .. 1.0 V for a lit indicator
	localparam logic signed [DC_W-1:0] DC_LIMIT   = 16'sd20480;
	localparam logic [LEVEL_W-1:0]     LIGHT_LOW  = 12'd512;
	localparam logic [LEVEL_W-1:0]     LIGHT_FULL = 12'd2048;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_COEF = 2'd0,
		REG_THR  = 2'd1
	} cfg_reg_t;

	// Control that travels alongside an item through the pipeline
	typedef struct packed {
		logic            vld;
		logic            hit;
		logic [CH_W-1:0] ch;
	} dcd_ctl_t;

endpackage

[rtl/dcd_store.sv]
module dcd_store import dcd_pkg::*; #(
	parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
) (
	input  logic                                        clk,
	input  logic                                        arst_n,
	input  logic                                        rd_en,
	input  logic [(NUM_CHANNELS > 1 ? $clog2(NUM_CHANNELS) : 1)-1:0] rd_addr,
	output logic [STATE_W-1:0]                          rd_data,
	input  logic                                        wr_en,
	input  logic [(NUM_CHANNELS > 1 ? $clog2(NUM_CHANNELS) : 1)-1:0] wr_addr,
	input  logic [STATE_W-1:0]                          wr_data
);

	logic [STATE_W-1:0]      mem [NUM_CHANNELS];
	logic [NUM_CHANNELS-1:0] written_q;
	logic [STATE_W-1:0]      rd_q;
	logic                    rd_written_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	// An entry that has never been written reads as zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			written_q    <= '0;
			rd_written_q <= 1'b0;
		end else begin
			if (wr_en) begin
				written_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_written_q <= written_q[rd_addr];
			end
		end
	end

	assign rd_data = rd_written_q ? rd_q : '0;

endmodule

[rtl/dcd_filter.sv]
module dcd_filter import dcd_pkg::*; (
	input  logic                       clk,
	input  logic                       en,
	input  logic                       load,
	input  logic signed [SAMPLE_W-1:0] sample,
	input  logic [COEF_W-1:0]          coef,
	input  logic [STATE_W-1:0]         state_rd,
	output logic [STATE_W-1:0]         new_state
);

	logic signed [SAMPLE_W-1:0]  x_s1;
	logic signed [STATE_W-1:0]   target;
	logic signed [STATE_W:0]     diff;
	logic signed [STATE_W:0]     d_s2;
	logic signed [STATE_W-1:0]   s_s2;
	logic signed [20:0]          d_hi;
	logic [19:0]                 d_lo;
	logic signed [COEF_W:0]      coef_s;
	logic signed [45:0]          pp_hi_s3;
	logic [43:0]                 pp_lo_s3;
	logic signed [STATE_W-1:0]   s_s3;
	logic signed [65:0]          full;
	logic signed [STATE_W:0]     step_s4;
	logic signed [STATE_W-1:0]   s_s4;
	logic signed [STATE_W:0]     sum;

	always_ff @(posedge clk) begin
		if (load) begin
			x_s1 <= sample;
		end
	end

	// Stage 1: difference between the scaled sample and the stored state.
	assign target = {x_s1, {FRAC_BITS{1'b0}}};
	assign diff   = (STATE_W+1)'(target) - (STATE_W+1)'($signed(state_rd));

	// Stage 2: the difference is split into a signed upper and unsigned lower part
	// so that each product stays within a narrow multiplier.
	assign d_hi   = d_s2[STATE_W:20];
	assign d_lo   = d_s2[19:0];
	assign coef_s = $signed({1'b0, coef});

	// Stage 3: recombine; taking the upper bits of the sum floors the scaled step.
	assign full = (66'(pp_hi_s3) <<< 20) + 66'($signed({1'b0, pp_lo_s3}));

	// Stage 4: move the state by the step.
	assign sum       = (STATE_W+1)'(s_s4) + step_s4;
	assign new_state = sum[STATE_W-1:0];

	always_ff @(posedge clk) begin
		if (en) begin
			d_s2     <= diff;
			s_s2     <= $signed(state_rd);
			pp_hi_s3 <= 46'(d_hi) * 46'(coef_s);
			pp_lo_s3 <= 44'(d_lo) * 44'(coef);
			s_s3     <= s_s2;
			step_s4  <= full[64:FRAC_BITS];
			s_s4     <= s_s3;
		end
	end

endmodule

[rtl/dcd_indicator.sv]
module dcd_indicator import dcd_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   en,
	input  dcd_ctl_t               ctl_s5,
	input  logic [STATE_W-1:0]     new_state,
	input  logic [THR_W-1:0]       threshold,
	output logic signed [DC_W-1:0] dc_level,
	output logic [LEVEL_W-1:0]     red_level,
	output logic [LEVEL_W-1:0]     green_level,
	output logic [LEVEL_W-1:0]     blue_level
);

	localparam logic signed [DC_W:0] LOW_S  = 17'(LIGHT_LOW);
	localparam logic signed [DC_W:0] FULL_S = 17'(LIGHT_FULL);

	logic signed [STATE_W-1:0] state_s5;
	logic signed [DC_W-1:0]    level;
	logic signed [DC_W-1:0]    dc_clamped;
	logic signed [STATE_W:0]   mag;
	logic                      near_zero;
	logic signed [DC_W:0]      pos_level;
	logic signed [DC_W:0]      neg_level;
	logic [LEVEL_W-1:0]        red_lit;
	logic [LEVEL_W-1:0]        blue_lit;
	logic signed [DC_W-1:0]    dc_q;
	logic [LEVEL_W-1:0]        red_q;
	logic [LEVEL_W-1:0]        green_q;
	logic [LEVEL_W-1:0]        blue_q;

	function automatic logic [LEVEL_W-1:0] light_clamp(input logic signed [DC_W:0] v);
		logic [LEVEL_W-1:0] r;
		if (v < LOW_S) begin
			r = LIGHT_LOW;
		end else if (v > FULL_S) begin
			r = LIGHT_FULL;
		end else begin
			r = v[LEVEL_W-1:0];
		end
		return r;
	endfunction

	always_ff @(posedge clk) begin
		if (en) begin
			state_s5 <= $signed(new_state);
		end
	end

	// The floor of the state is its upper bits.
	assign level = state_s5[STATE_W-1:FRAC_BITS];

	always_comb begin
		if (level > DC_LIMIT) begin
			dc_clamped = DC_LIMIT;
		end else if (level < -DC_LIMIT) begin
			dc_clamped = -DC_LIMIT;
		end else begin
			dc_clamped = level;
		end
	end

	assign mag       = state_s5[STATE_W-1] ? -(STATE_W+1)'(state_s5) : (STATE_W+1)'(state_s5);
	assign near_zero = mag < $signed((STATE_W+1)'({threshold, {FRAC_BITS{1'b0}}}));
	assign pos_level = (DC_W+1)'(level);
	assign neg_level = -(DC_W+1)'(level);
	assign red_lit   = light_clamp(pos_level);
	assign blue_lit  = light_clamp(neg_level);

	always_ff @(posedge clk) begin
		if (en && ctl_s5.vld) begin
			dc_q <= ctl_s5.hit ? dc_clamped : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			red_q   <= '0;
			green_q <= '0;
			blue_q  <= '0;
		end else if (en && ctl_s5.vld && ctl_s5.hit && ctl_s5.ch == '0) begin
			if (near_zero) begin
				red_q   <= '0;
				green_q <= LIGHT_FULL;
				blue_q  <= '0;
			end else if (state_s5[STATE_W-1]) begin
				red_q   <= '0;
				green_q <= '0;
				blue_q  <= blue_lit;
			end else begin
				red_q   <= red_lit;
				green_q <= '0;
				blue_q  <= '0;
			end
		end
	end

	assign dc_level    = dc_q;
	assign red_level   = red_q;
	assign green_level = green_q;
	assign blue_level  = blue_q;

endmodule

[rtl/multichannel_dc_level_detector.sv]
// Throughput: one item per cycle; an item whose channel matches one of the four items ahead
// of it waits for that state write-back, and a result held at the output stalls the
// whole pipeline, input included.
// Reset: arst_n clears the pipeline, the output valid, the indicator levels and the
// per-channel written flags, so every filter state reads as zero; registers take defaults.
module multichannel_dc_level_detector import dcd_pkg::*; #(
	parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	input  logic [15:0]          s_axis_tdata,   // [15:0] sample
	input  logic [CH_W-1:0]      s_axis_tuser,   // [3:0] channel
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	output logic [55:0]          m_axis_tdata,   // [15:0] dc_level, [27:16] red_level,
	                                             // [39:28] green_level, [51:40] blue_level
	output logic [CH_W-1:0]      m_axis_tuser,   // [3:0] out_channel
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [COEF_W-1:0]    cfg_data
);

	localparam int AW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

	logic [COEF_W-1:0] coef_q;
	logic [THR_W-1:0]  thr_q;

	dcd_ctl_t ctl_s1;
	dcd_ctl_t ctl_s2;
	dcd_ctl_t ctl_s3;
	dcd_ctl_t ctl_s4;
	dcd_ctl_t ctl_s5;
	dcd_ctl_t in_ctl;

	logic                   en;
	logic                   in_acc;
	logic                   in_hit;
	logic                   hazard;
	logic                   store_rd;
	logic                   store_we;
	logic [AW-1:0]          rd_addr;
	logic [AW-1:0]          wr_addr;
	logic [STATE_W-1:0]     state_rd;
	logic [STATE_W-1:0]     new_state;
	logic                   m_valid_q;
	logic [CH_W-1:0]        out_ch_q;
	logic signed [DC_W-1:0] dc_level;
	logic [LEVEL_W-1:0]     red_level;
	logic [LEVEL_W-1:0]     green_level;
	logic [LEVEL_W-1:0]     blue_level;

	// Configuration writes are always taken; an index beyond the register list is dropped.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q <= COEF_RESET;
			thr_q  <= THR_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_COEF: coef_q <= cfg_data;
				REG_THR:  thr_q  <= cfg_data[THR_W-1:0];
				default:  ;
			endcase
		end
	end

	// The whole pipeline advances together whenever the output register can take an item.
	assign en = !m_valid_q || m_axis_tready;

	// A channel that is still being read, computed or written back may not be read again
	// until its new state has reached the memory.
	assign hazard = (ctl_s1.vld && ctl_s1.ch == s_axis_tuser)
	             || (ctl_s2.vld && ctl_s2.ch == s_axis_tuser)
	             || (ctl_s3.vld && ctl_s3.ch == s_axis_tuser)
	             || (ctl_s4.vld && ctl_s4.ch == s_axis_tuser);

	assign s_axis_tready = en && !hazard;
	assign in_acc        = s_axis_tvalid && s_axis_tready;

	// Channels beyond the configured count touch no state.
	assign in_hit     = 32'(s_axis_tuser) < NUM_CHANNELS;
	assign in_ctl.vld = 1'b1;
	assign in_ctl.hit = in_hit;
	assign in_ctl.ch  = s_axis_tuser;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			ctl_s3 <= '0;
			ctl_s4 <= '0;
			ctl_s5 <= '0;
		end else if (en) begin
			ctl_s1 <= in_acc ? in_ctl : '0;
			ctl_s2 <= ctl_s1;
			ctl_s3 <= ctl_s2;
			ctl_s4 <= ctl_s3;
			ctl_s5 <= ctl_s4;
		end
	end

	// The state is read as the item is accepted and written back as it leaves stage four.
	assign store_rd = in_acc && in_hit;
	assign rd_addr  = AW'(s_axis_tuser);
	assign store_we = en && ctl_s4.vld && ctl_s4.hit;
	assign wr_addr  = AW'(ctl_s4.ch);

	dcd_store #(
		.NUM_CHANNELS(NUM_CHANNELS)
	) u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (store_rd),
		.rd_addr (rd_addr),
		.rd_data (state_rd),
		.wr_en   (store_we),
		.wr_addr (wr_addr),
		.wr_data (new_state)
	);

	dcd_filter u_filter (
		.clk       (clk),
		.en        (en),
		.load      (in_acc),
		.sample    ($signed(s_axis_tdata)),
		.coef      (coef_q),
		.state_rd  (state_rd),
		.new_state (new_state)
	);

	dcd_indicator u_indicator (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (en),
		.ctl_s5      (ctl_s5),
		.new_state   (new_state),
		.threshold   (thr_q),
		.dc_level    (dc_level),
		.red_level   (red_level),
		.green_level (green_level),
		.blue_level  (blue_level)
	);

	// Output register: holds a finished item; while it waits the whole pipeline stands still.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (en) begin
			m_valid_q <= ctl_s5.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en && ctl_s5.vld) begin
			out_ch_q <= ctl_s5.ch;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tuser  = out_ch_q;
	assign m_axis_tdata  = {4'b0, blue_level, green_level, red_level, dc_level};

	// The interlock must keep a write-back and a new read of the same entry apart.
	assert property (@(posedge clk) disable iff (!arst_n)
		(store_we && store_rd) |-> (wr_addr != rd_addr))
		else $error("state read and write-back hit the same channel");

	// At most one indicator is lit at any time.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> $onehot0({red_level != '0, green_level != '0, blue_level != '0}))
		else $error("more than one indicator lit");

	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (dc_level <= DC_LIMIT && dc_level >= -DC_LIMIT))
		else $error("dc level outside the saturation range");

	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(ctl_s5.vld))
		else $error("result presented without an item in the last stage");

endmodule
